// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of the triangle adjacency block.
// Every macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TEA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tea check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define TEA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tea check failed");

`endif

// ----- hdl/tea_pkg.sv -----
// Shared types, codes and sizes for the triangle adjacency block.
// It depends on nothing. All files but tea_ram and assert_macros.svh import it.
`timescale 1ns / 1ps

package tea_pkg;

  localparam int MAX_CELLS = 64;
  localparam int IDX_W     = 6;
  localparam int ADDR_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CNT_W     = $clog2(MAX_CELLS + 1);
  localparam int CMP_W     = IDX_W + 1;
  localparam int COORD_W   = 32;
  localparam int VERTS     = 3;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] ST_LOADED    = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NEIGHBOUR = 3'd2;
  localparam logic [2:0] ST_NONE      = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;
  localparam logic [2:0] ST_BAD_INDEX = 3'd5;

  // One vertex is its x, y and z words; a cell row holds vertices a, b, c at 0, 1, 2.
  typedef logic [3*COORD_W-1:0] vertex_t;
  typedef vertex_t [VERTS-1:0] cell_row_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [COORD_W-1:0] vertex_a_x;
    logic [COORD_W-1:0] vertex_a_y;
    logic [COORD_W-1:0] vertex_a_z;
    logic [COORD_W-1:0] vertex_b_x;
    logic [COORD_W-1:0] vertex_b_y;
    logic [COORD_W-1:0] vertex_b_z;
    logic [COORD_W-1:0] vertex_c_x;
    logic [COORD_W-1:0] vertex_c_y;
    logic [COORD_W-1:0] vertex_c_z;
    logic [IDX_W-1:0]   query_cell;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] cell_index;
    logic [IDX_W-1:0] neighbour_index;
    logic             last;
  } res_item_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_QROW,
    FSM_SCAN
  } fsm_state_t;

endpackage

// ----- hdl/tea_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// It depends on nothing; read data holds its value while no read is enabled.
`timescale 1ns / 1ps

module tea_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 288,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/tea_match.sv -----
// Shared-vertex test between the queried cell and one stored cell.
// It depends on tea_pkg for the cell row type.
`timescale 1ns / 1ps

module tea_match (
  input  tea_pkg::cell_row_t qrow,
  input  tea_pkg::cell_row_t crow,
  output logic               neighbour
);
  import tea_pkg::*;

  logic [VERTS-1:0] hit;

  // A vertex of the queried cell counts once if it equals any vertex of the other cell.
  always_comb begin
    for (int i = 0; i < VERTS; i++) begin
      hit[i] = 1'b0;
      for (int j = 0; j < VERTS; j++) begin
        hit[i] = hit[i] | (qrow[i] == crow[j]);
      end
    end
  end

  // Exactly two shared vertices make an edge neighbour.
  assign neighbour = (hit[0] & hit[1] & ~hit[2]) |
                     (hit[0] & ~hit[1] & hit[2]) |
                     (~hit[0] & hit[1] & hit[2]);

endmodule

// ----- hdl/triangle_edge_adjacency_finder.sv -----
// Top level of the triangle adjacency block: control sequencer, cell count and result register.
// It depends on tea_pkg, tea_ram (cell table) and tea_match (shared-vertex test).
`timescale 1ns / 1ps

// Channel   Handshake              Payload      Direction
// -------   --------------------   ----------   ---------
// cmd       cmd_valid / cmd_stall  cmd_item_t   into the block
// res       res_valid / res_stall  res_item_t   out of the block
//
// A load or a clear yields its single item in the next cycle.
// A query reads the queried row, starts the scan, reads each stored cell in turn through the
// single read port of the cell table, and then closes.
// Reset (synchronous, active high) empties the table; the table RAM itself is not cleared.
// A stalled result register pauses the scan where a hit must push out a held neighbour; no
// new command is taken until the current one has handed its last item to the result register.

module triangle_edge_adjacency_finder (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  tea_pkg::cmd_item_t cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output tea_pkg::res_item_t res
);
  import tea_pkg::*;

  fsm_state_t state, state_next;

  logic [CNT_W-1:0]  cell_count;
  logic [IDX_W-1:0]  query;
  cell_row_t         qrow;
  cell_row_t         wrow;
  cell_row_t         rdata;
  logic [CNT_W-1:0]  scan_addr;
  logic [ADDR_W-1:0] rd_idx;
  logic              cmp_valid;
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_idx;

  logic              accept;
  logic              out_free;
  logic              full;
  logic              bad;
  logic              scan_more;
  logic              neighbour;
  logic              hit;

  logic              emit;
  res_item_t         emit_item;
  logic              we;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic              load_cell;
  logic              clear_cells;
  logic              start_query;
  logic              start_scan;
  logic              step;
  logic              take_hit;
  logic              finish;

  // The result register may take an item when it is empty or is being drained.
  // No command is taken while reset is held.
  assign out_free  = !res_valid || !res_stall;
  assign cmd_stall = rst || !((state == FSM_IDLE) && out_free);
  assign accept    = cmd_valid && !cmd_stall;

  assign full      = cell_count >= CNT_W'(MAX_CELLS);
  assign bad       = {1'b0, cmd.query_cell} >= CMP_W'(cell_count);
  assign scan_more = scan_addr < cell_count;

  // The queried cell always matches itself in all three vertices, but it is
  // excluded by index as well so that the rule does not rest on that.
  assign hit = cmp_valid && neighbour && (CMP_W'(rd_idx) != {1'b0, query});

  assign wrow[0] = {cmd.vertex_a_x, cmd.vertex_a_y, cmd.vertex_a_z};
  assign wrow[1] = {cmd.vertex_b_x, cmd.vertex_b_y, cmd.vertex_b_z};
  assign wrow[2] = {cmd.vertex_c_x, cmd.vertex_c_y, cmd.vertex_c_z};

  // One row per cell, so a load is a single write and the scan reads one cell a cycle unless
  // a busy result register holds it up. Writes happen only in the idle state and reads only
  // during a query, so the two ports never touch the same row in the same cycle.
  tea_ram #(
    .DEPTH (MAX_CELLS),
    .WIDTH ($bits(cell_row_t))
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cell_count[ADDR_W-1:0]),
    .wdata (wrow),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  tea_match u_match (
    .qrow      (qrow),
    .crow      (rdata),
    .neighbour (neighbour)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (start_query) begin
          state_next = FSM_QROW;
        end
      end
      FSM_QROW: begin
        state_next = FSM_SCAN;
      end
      FSM_SCAN: begin
        if (finish) begin
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  // Control strobes and the result item to be written.
  always_comb begin
    emit        = 1'b0;
    emit_item   = '0;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = '0;
    load_cell   = 1'b0;
    clear_cells = 1'b0;
    start_query = 1'b0;
    start_scan  = 1'b0;
    step        = 1'b0;
    take_hit    = 1'b0;
    finish      = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          unique case (cmd.action)
            ACT_LOAD: begin
              emit           = 1'b1;
              emit_item.last = 1'b1;
              if (full) begin
                emit_item.status = ST_FULL;
              end else begin
                we                   = 1'b1;
                load_cell            = 1'b1;
                emit_item.status     = ST_LOADED;
                emit_item.cell_index = IDX_W'(cell_count);
              end
            end
            ACT_QUERY: begin
              if (bad) begin
                emit                 = 1'b1;
                emit_item.status     = ST_BAD_INDEX;
                emit_item.cell_index = cmd.query_cell;
                emit_item.last       = 1'b1;
              end else begin
                re          = 1'b1;
                raddr       = cmd.query_cell[ADDR_W-1:0];
                start_query = 1'b1;
              end
            end
            ACT_CLEAR: begin
              emit             = 1'b1;
              clear_cells      = 1'b1;
              emit_item.status = ST_CLEARED;
              emit_item.last   = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      FSM_QROW: begin
        // The queried row is on the read port now; start reading from cell zero.
        re         = 1'b1;
        raddr      = '0;
        start_scan = 1'b1;
      end
      FSM_SCAN: begin
        if (cmp_valid) begin
          // A new hit pushes out the held neighbour; if the result register is
          // busy the scan waits with the current row held on the read port.
          if (!(hit && pend_valid && !out_free)) begin
            step     = 1'b1;
            take_hit = hit;
            if (hit && pend_valid) begin
              emit                      = 1'b1;
              emit_item.status          = ST_NEIGHBOUR;
              emit_item.cell_index      = query;
              emit_item.neighbour_index = IDX_W'(pend_idx);
            end
            if (scan_more) begin
              re    = 1'b1;
              raddr = scan_addr[ADDR_W-1:0];
            end
          end
        end else if (out_free) begin
          // All cells compared: the held neighbour, if any, is the last item.
          finish               = 1'b1;
          emit                 = 1'b1;
          emit_item.cell_index = query;
          emit_item.last       = 1'b1;
          if (pend_valid) begin
            emit_item.status          = ST_NEIGHBOUR;
            emit_item.neighbour_index = IDX_W'(pend_idx);
          end else begin
            emit_item.status = ST_NONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FSM_IDLE;
      cell_count <= '0;
      res_valid  <= 1'b0;
      cmp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_cell) begin
        cell_count <= cell_count + CNT_W'(1);
      end else if (clear_cells) begin
        cell_count <= '0;
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (start_scan) begin
        cmp_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (step) begin
        cmp_valid <= scan_more;
        if (take_hit) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (emit) begin
      res <= emit_item;
    end
    if (start_query) begin
      query <= cmd.query_cell;
    end
    if (start_scan) begin
      qrow      <= rdata;
      rd_idx    <= '0;
      scan_addr <= CNT_W'(1);
    end else if (step) begin
      if (take_hit) begin
        pend_idx <= rd_idx;
      end
      if (scan_more) begin
        rd_idx    <= scan_addr[ADDR_W-1:0];
        scan_addr <= scan_addr + CNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/tea_checker.sv -----
// Port-level checks on the triangle adjacency block, attached to the top level by bind.
// It depends on tea_pkg and on the macros in assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tea_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_stall,
  input tea_pkg::cmd_item_t cmd,
  input logic               res_valid,
  input logic               res_stall,
  input tea_pkg::res_item_t res
);
  import tea_pkg::*;

  // A result held back by the receiver stays in place.
  `TEA_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

  // A taken clear answers in the next cycle with a single final cleared item.
  `TEA_ASSERT_NEXT(a_clear_reply, cmd_valid && !cmd_stall && cmd.action == ACT_CLEAR, res_valid && res.status == ST_CLEARED && res.last)

  // Only neighbour items can be followed by more items of the same command.
  `TEA_ASSERT_NOW(a_single_last, res_valid && res.status != ST_NEIGHBOUR, res.last)

  // A cell is never reported as its own neighbour.
  `TEA_ASSERT_NOW(a_not_self, res_valid && res.status == ST_NEIGHBOUR, res.neighbour_index != res.cell_index)

endmodule

bind triangle_edge_adjacency_finder tea_checker u_tea_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

// ----- test/tb_top.sv -----
// Self-checking bench for triangle_edge_adjacency_finder: loads, clears and neighbour queries,
// checked item by item against an in-bench table model. Depends on tea_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_top;
  import tea_pkg::*;

  // Action code 3 has no name in the package; the block drops such items without a result.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int ITEM_GOAL    = 230;
  localparam int REPORT_MAX   = 10;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = MAX_CELLS + 16;

  typedef struct packed {
    cmd_item_t item;
    logic      typed;
    res_item_t want;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_item_t cmd       = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res;

  triangle_edge_adjacency_finder dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #10 clk = ~clk;

  // Bench copy of the triangle table and its fill level.
  vertex_t   cell_verts [MAX_CELLS][VERTS];
  int        stored_cells = 0;
  res_item_t predicted[$];
  res_item_t pending_results[$];
  dir_row_t  dir_rows[$];
  vertex_t   pool [8];
  int        pool_size = 3;
  int        fails = 0;
  int        work_items = 0;
  int        taken = 0;
  bit        quiet = 1'b0;

  function automatic res_item_t mk_res(logic [2:0] st, logic [IDX_W-1:0] cidx,
                                       logic [IDX_W-1:0] nb, logic lst);
    res_item_t r;
    r.status          = st;
    r.cell_index      = cidx;
    r.neighbour_index = nb;
    r.last            = lst;
    return r;
  endfunction

  function automatic vertex_t rand_vertex();
    return {$urandom, $urandom, $urandom};
  endfunction

  function automatic cmd_item_t mk_load(vertex_t a, vertex_t b, vertex_t c);
    cmd_item_t t;
    t.action = ACT_LOAD;
    {t.vertex_a_x, t.vertex_a_y, t.vertex_a_z} = a;
    {t.vertex_b_x, t.vertex_b_y, t.vertex_b_z} = b;
    {t.vertex_c_x, t.vertex_c_y, t.vertex_c_z} = c;
    t.query_cell = IDX_W'($urandom_range(0, 63));
    return t;
  endfunction

  // Non-load items carry random coordinates, which the block must ignore.
  function automatic cmd_item_t mk_cmd(logic [1:0] act, logic [IDX_W-1:0] q);
    cmd_item_t t;
    t = mk_load(rand_vertex(), rand_vertex(), rand_vertex());
    t.action     = act;
    t.query_cell = q;
    return t;
  endfunction

  function automatic void add_row(cmd_item_t it, logic typed, res_item_t want);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Each vertex of cell p adds one if any vertex of cell r equals it in all three words.
  function automatic int shared_count(int p, int r);
    int  hits;
    bit  seen;
    int  i;
    int  j;
    hits = 0;
    for (i = 0; i < VERTS; i++) begin
      seen = 1'b0;
      for (j = 0; j < VERTS; j++) begin
        if (cell_verts[p][i] == cell_verts[r][j]) seen = 1'b1;
      end
      if (seen) hits++;
    end
    return hits;
  endfunction

  // Works out the result items of one accepted item and updates the table copy.
  function automatic void predict_item(cmd_item_t it);
    int q;
    int c;
    int top_nb;
    predicted.delete();
    case (it.action)
      ACT_LOAD: begin
        if (stored_cells >= MAX_CELLS) begin
          predicted.insert(predicted.size(), mk_res(ST_FULL, '0, '0, 1'b1));
        end else begin
          cell_verts[stored_cells][0] = {it.vertex_a_x, it.vertex_a_y, it.vertex_a_z};
          cell_verts[stored_cells][1] = {it.vertex_b_x, it.vertex_b_y, it.vertex_b_z};
          cell_verts[stored_cells][2] = {it.vertex_c_x, it.vertex_c_y, it.vertex_c_z};
          predicted.insert(predicted.size(),
                           mk_res(ST_LOADED, stored_cells[IDX_W-1:0], '0, 1'b1));
          stored_cells++;
        end
      end
      ACT_QUERY: begin
        q = int'(it.query_cell);
        if (q >= stored_cells) begin
          predicted.insert(predicted.size(), mk_res(ST_BAD_INDEX, it.query_cell, '0, 1'b1));
        end else begin
          // First pass finds the highest neighbour, which carries the last flag.
          top_nb = -1;
          for (c = 0; c < stored_cells; c++) begin
            if (c != q && shared_count(q, c) == 2) top_nb = c;
          end
          if (top_nb < 0) begin
            predicted.insert(predicted.size(), mk_res(ST_NONE, it.query_cell, '0, 1'b1));
          end else begin
            for (c = 0; c < stored_cells; c++) begin
              if (c != q && shared_count(q, c) == 2) begin
                predicted.insert(predicted.size(),
                                 mk_res(ST_NEIGHBOUR, it.query_cell, c[IDX_W-1:0],
                                        c == top_nb));
              end
            end
          end
        end
      end
      ACT_CLEAR: begin
        stored_cells = 0;
        predicted.insert(predicted.size(), mk_res(ST_CLEARED, '0, '0, 1'b1));
      end
      default: begin
      end
    endcase
  endfunction

  function automatic vertex_t pool_vertex();
    if ($urandom_range(0, 9) == 0) return rand_vertex();
    return pool[$urandom_range(0, pool_size - 1)];
  endfunction

  function automatic logic [IDX_W-1:0] pick_query();
    if (stored_cells > 0 && $urandom_range(0, 5) != 0)
      return IDX_W'($urandom_range(0, stored_cells - 1));
    return IDX_W'($urandom_range(0, 63));
  endfunction

  // Offers one item after a random gap and returns at the edge that accepts it. Valid stays
  // high afterwards so that a back-to-back item follows without a bubble.
  task automatic drive_item(cmd_item_t it, logic typed, res_item_t want);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= it;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_item(it);
    if (typed) begin
      pending_results.insert(pending_results.size(), want);
    end else begin
      foreach (predicted[i]) pending_results.insert(pending_results.size(), predicted[i]);
    end
    if (it.action != ACT_UNUSED) work_items++;
  endtask

  // Result side: a random stall before each item, and two long hold-offs that back the
  // block up until it stops taking commands.
  initial begin
    int k;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == 25 || taken == 200) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        k = quiet ? 0 : $urandom_range(0, 7);
        if (k > 0) begin
          res_stall <= 1'b1;
          repeat (k) @(posedge clk);
        end
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      taken++;
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("unexpected result: status %0d cell %0d nbr %0d last %0d",
                   res.status, res.cell_index, res.neighbour_index, res.last);
      end else begin
        want = pending_results.pop_front();
        if (res.status !== want.status || res.cell_index !== want.cell_index ||
            res.neighbour_index !== want.neighbour_index || res.last !== want.last) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("result differs: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.status, want.cell_index, want.neighbour_index, want.last,
                     res.status, res.cell_index, res.neighbour_index, res.last);
        end
      end
    end
  end

  initial begin
    #16_000_000;
    $display("triangle_edge_adjacency_finder: mismatch");
    $finish;
  end

  initial begin
    dir_row_t row;
    vertex_t  v0;
    vertex_t  v1;
    vertex_t  v2;
    vertex_t  v3;
    vertex_t  v4;
    vertex_t  v5;
    int       ep;
    int       loads;
    int       done;
    int       pick;
    int       load_cut;
    int       nq;
    int       k;
    bit       fill;

    v0 = '0;
    v1 = '1;
    v2 = {32'd1, 32'd2, 32'd3};
    v3 = {32'd4, 32'd5, 32'd6};
    v4 = {32'd7, 32'd8, 32'd9};
    v5 = {32'd1, 32'd2, 32'd4};   // differs from v2 only in z

    // Directed table: empty-table queries, the index extremes, identical and degenerate
    // triangles, a near-miss vertex, dropped action codes and a clear with reload.
    add_row(mk_cmd(ACT_QUERY, 6'd0), 1'b1, mk_res(ST_BAD_INDEX, 6'd0, '0, 1'b1));
    add_row(mk_cmd(ACT_QUERY, 6'd63), 1'b1, mk_res(ST_BAD_INDEX, 6'd63, '0, 1'b1));
    add_row(mk_cmd(ACT_CLEAR, 6'd0), 1'b1, mk_res(ST_CLEARED, '0, '0, 1'b1));
    add_row(mk_cmd(ACT_UNUSED, 6'd63), 1'b0, '0);
    add_row(mk_load(v0, v1, v2), 1'b1, mk_res(ST_LOADED, 6'd0, '0, 1'b1));
    add_row(mk_load(v1, v2, v3), 1'b1, mk_res(ST_LOADED, 6'd1, '0, 1'b1));
    add_row(mk_load(v0, v1, v2), 1'b1, mk_res(ST_LOADED, 6'd2, '0, 1'b1));
    add_row(mk_load(v2, v2, v2), 1'b1, mk_res(ST_LOADED, 6'd3, '0, 1'b1));
    add_row(mk_load(v5, v3, v4), 1'b1, mk_res(ST_LOADED, 6'd4, '0, 1'b1));
    add_row(mk_load(v4, v1, v3), 1'b1, mk_res(ST_LOADED, 6'd5, '0, 1'b1));
    for (k = 0; k < 6; k++) add_row(mk_cmd(ACT_QUERY, k[IDX_W-1:0]), 1'b0, '0);
    add_row(mk_cmd(ACT_QUERY, 6'd6), 1'b1, mk_res(ST_BAD_INDEX, 6'd6, '0, 1'b1));
    add_row(mk_cmd(ACT_UNUSED, 6'd0), 1'b0, '0);
    add_row(mk_cmd(ACT_CLEAR, 6'd63), 1'b1, mk_res(ST_CLEARED, '0, '0, 1'b1));
    add_row(mk_cmd(ACT_QUERY, 6'd0), 1'b1, mk_res(ST_BAD_INDEX, 6'd0, '0, 1'b1));
    add_row(mk_load(v1, v1, v1), 1'b1, mk_res(ST_LOADED, 6'd0, '0, 1'b1));
    add_row(mk_cmd(ACT_QUERY, 6'd0), 1'b1, mk_res(ST_NONE, 6'd0, '0, 1'b1));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      drive_item(row.item, row.typed, row.want);
    end

    // Random episodes: a small vertex pool per episode makes shared edges common. The
    // second episode fills the table past capacity and queries its outermost cells.
    ep = 0;
    while (work_items < ITEM_GOAL || ep < 3) begin
      quiet = ($urandom_range(0, 3) == 0);
      fill  = (ep == 1);
      if (fill || $urandom_range(0, 4) != 0)
        drive_item(mk_cmd(ACT_CLEAR, IDX_W'($urandom_range(0, 63))), 1'b0, '0);
      pool_size = $urandom_range(3, 6);
      for (k = 0; k < pool_size; k++) begin
        pool[k] = rand_vertex();
        // Some vertices sit one bit away from an earlier one.
        if (k > 0 && $urandom_range(0, 2) == 0)
          pool[k] = pool[$urandom_range(0, k - 1)] ^ (vertex_t'(1) << $urandom_range(0, 95));
      end
      loads    = fill ? MAX_CELLS + 2 : $urandom_range(2, 12);
      load_cut = fill ? 17 : 11;
      done     = 0;
      while (done < loads) begin
        pick = $urandom_range(0, 19);
        if (pick < load_cut) begin
          drive_item(mk_load(pool_vertex(), pool_vertex(), pool_vertex()), 1'b0, '0);
          done++;
        end else if (pick == 19 && !fill) begin
          drive_item(mk_cmd(ACT_CLEAR, IDX_W'($urandom_range(0, 63))), 1'b0, '0);
        end else if (pick == 18) begin
          drive_item(mk_cmd(ACT_UNUSED, IDX_W'($urandom_range(0, 63))), 1'b0, '0);
        end else begin
          drive_item(mk_cmd(ACT_QUERY, pick_query()), 1'b0, '0);
        end
      end
      if (fill) begin
        drive_item(mk_cmd(ACT_QUERY, 6'd63), 1'b0, '0);
        drive_item(mk_cmd(ACT_QUERY, 6'd0), 1'b0, '0);
      end
      nq = $urandom_range(2, 5);
      for (k = 0; k < nq; k++) drive_item(mk_cmd(ACT_QUERY, pick_query()), 1'b0, '0);
      ep++;
    end
    cmd_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("triangle_edge_adjacency_finder: match");
    end else begin
      $display("triangle_edge_adjacency_finder: mismatch");
    end
    $finish;
  end

endmodule
